FILE: src/hlsd_pkg.sv
// ----------------------------------------------------------------------------
// hlsd_pkg
// Shared types and constants of the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package hlsd_pkg;

  // Reset value of the header byte register
  localparam logic [7:0] DefaultHeader = 8'hAA;

  // Result kind codes
  localparam logic KindPayload = 1'b0;
  localparam logic KindEnd     = 1'b1;

  // One result beat
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [7:0] index;
    logic [7:0] pkt_length;
    logic       checksum_ok;
  } result_t;

endpackage : hlsd_pkg

`default_nettype wire

FILE: src/hlsd_in_stage.sv
// ----------------------------------------------------------------------------
// hlsd_in_stage
// Input register: captures one received byte per beat and holds it until the
// frame tracker takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hlsd_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       rx_valid_i,
  output logic            rx_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            byte_valid_o,
  output logic [7:0]      byte_o,
  input  wire logic       advance_i
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  // Take a new beat when empty or when the held byte moves on this cycle
  assign rx_ready_o = !valid_q || advance_i;
  assign load       = rx_valid_i && rx_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_byte_i;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule : hlsd_in_stage

`default_nettype wire

FILE: src/hlsd_frame.sv
// ----------------------------------------------------------------------------
// hlsd_frame
// Frame tracker: hunts for the header, takes the length, streams payload bytes
// with their index while summing them, then checks the checksum byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hlsd_frame (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire logic [7:0]       byte_i,
  input  wire logic [7:0]       header_i,
  output logic                  res_valid_o,
  output hlsd_pkg::result_t     res_o
);

  typedef enum logic [1:0] {
    PhHunt    = 2'd0,
    PhLength  = 2'd1,
    PhPayload = 2'd2,
    PhCheck   = 2'd3
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] count_q, count_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] len_q, len_d;
  logic [7:0] count_inc;

  assign count_inc = count_q + 8'd1;

  // Next state and result for the byte presented this cycle
  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    sum_d       = sum_q;
    len_d       = len_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: hlsd_pkg::KindPayload, data: byte_i, index: count_q,
                    pkt_length: len_q, checksum_ok: 1'b0};
    unique case (phase_q)
      PhHunt: begin
        if (byte_i == header_i) begin
          phase_d = PhLength;
        end
      end
      PhLength: begin
        len_d   = byte_i;
        count_d = '0;
        sum_d   = '0;
        // zero length goes straight to the checksum byte
        phase_d = (byte_i == 8'd0) ? PhCheck : PhPayload;
      end
      PhPayload: begin
        res_valid_o = 1'b1;
        sum_d       = sum_q + byte_i;
        count_d     = count_inc;
        if (count_inc == len_q) begin
          phase_d = PhCheck;
        end
      end
      PhCheck: begin
        res_valid_o       = 1'b1;
        res_o.kind        = hlsd_pkg::KindEnd;
        res_o.index       = '0;
        res_o.checksum_ok = (sum_q == byte_i);
        phase_d           = PhHunt;
        count_d           = '0;
        sum_d             = '0;
        len_d             = '0;
      end
      default: begin
        phase_d = PhHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      count_q <= '0;
      sum_q   <= '0;
      len_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      len_q   <= len_d;
    end
  end

endmodule : hlsd_frame

`default_nettype wire

FILE: src/hlsd_out_stage.sv
// ----------------------------------------------------------------------------
// hlsd_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hlsd_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire hlsd_pkg::result_t res_i,
  output logic                   space_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output hlsd_pkg::result_t      res_o
);

  logic              valid_q, valid_d;
  hlsd_pkg::result_t res_q;

  // Room for a new beat when empty or when the held one leaves now
  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule : hlsd_out_stage

`default_nettype wire

FILE: src/header_length_sum_deframer_core.sv
// ----------------------------------------------------------------------------
// header_length_sum_deframer_core
// Receiver for length-prefixed byte frames with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
// One received byte per beat on rx. After a byte equal to the header register
// (0xAA after reset) the next byte is the payload length; that many payload
// bytes follow, each giving a result beat with kind payload and its index,
// then a checksum byte giving a packet-end beat with the length and whether
// the modulo-256 payload sum matched. Header and length bytes give nothing;
// a zero length goes straight to the checksum byte. A byte is held in the
// input register until the result register can take its beat, and its result
// is loaded into the result register as it moves on. The block takes one byte
// every cycle as long as the result register is free or being emptied. The
// header register is written through the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module header_length_sum_deframer_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_header_byte_i,
  // received bytes
  input  wire logic       rx_valid_i,
  output logic            rx_ready_o,
  input  wire logic [7:0] rx_byte_i,
  // results
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            kind_o,
  output logic [7:0]      data_o,
  output logic [7:0]      index_o,
  output logic [7:0]      pkt_length_o,
  output logic            checksum_ok_o
);

  logic              header_we;
  logic [7:0]        header_byte_q;
  logic              byte_valid;
  logic [7:0]        byte_held;
  logic              advance;
  logic              res_valid;
  logic              space;
  hlsd_pkg::result_t res_comb;
  hlsd_pkg::result_t res_out;

  // Header byte register
  assign cfg_ready_o = 1'b1;
  assign header_we   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_byte_q <= hlsd_pkg::DefaultHeader;
    end else if (header_we) begin
      header_byte_q <= cfg_header_byte_i;
    end
  end

  // Held byte moves on when the result register can take its beat
  assign advance = byte_valid && space;

  hlsd_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .rx_byte_i    (rx_byte_i),
    .byte_valid_o (byte_valid),
    .byte_o       (byte_held),
    .advance_i    (advance)
  );

  hlsd_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .byte_i      (byte_held),
    .header_i    (header_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res_comb)
  );

  hlsd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .res_i       (res_comb),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign kind_o        = res_out.kind;
  assign data_o        = res_out.data;
  assign index_o       = res_out.index;
  assign pkt_length_o  = res_out.pkt_length;
  assign checksum_ok_o = res_out.checksum_ok;

  // Checks
  a_end_index_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == hlsd_pkg::KindEnd) |-> (index_o == 8'd0))
    else $error("packet-end beat with non-zero index");

  a_payload_no_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == hlsd_pkg::KindPayload) |-> !checksum_ok_o)
    else $error("payload beat with checksum flag set");

  a_payload_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == hlsd_pkg::KindPayload) |-> (index_o < pkt_length_o))
    else $error("payload index beyond declared length");

  a_no_load_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && byte_valid |=> $stable(res_out))
    else $error("result register overwritten while stalled");

endmodule : header_length_sum_deframer_core

`default_nettype wire

FILE: test/tb_header_length_sum_deframer_core.sv
// ----------------------------------------------------------------------------
// tb_header_length_sum_deframer_core
// Self-checking testbench for the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
// Received bytes are pushed through the rx channel. A frame tracker in the
// bench follows header, length, payload and checksum for every accepted beat
// and queues the result beats it expects. Each result beat is then checked
// field by field against the oldest queued entry. The run starts with
// hand-picked frames and moves on to header register sweeps, a maximum-length
// frame and a long result hold-off. It ends with random frame traffic under
// several header settings, with random idle bursts on both sides except in
// the final stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_header_length_sum_deframer_core;

  localparam int unsigned SettleCycles  = 6;
  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned WatchdogLimit = 2000;

  // Frame tracker phases
  typedef enum logic [1:0] {
    SeekHeader,
    TakeLength,
    TakePayload,
    TakeChecksum
  } frame_phase_e;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [7:0] cfg_header_byte_i;
  logic       rx_valid_i;
  logic       rx_ready_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       kind_o;
  logic [7:0] data_o;
  logic [7:0] index_o;
  logic [7:0] pkt_length_o;
  logic       checksum_ok_o;

  // Frame tracker state, mirrors the block after reset
  frame_phase_e trk_phase  = SeekHeader;
  logic [7:0]   trk_count  = '0;
  logic [7:0]   trk_sum    = '0;
  logic [7:0]   trk_length = '0;
  logic [7:0]   hdr_reg    = hlsd_pkg::DefaultHeader;

  hlsd_pkg::result_t exp_beats[$];

  // Control shared between the stimulus, the result sink and the monitor
  logic [7:0]  header_setting = hlsd_pkg::DefaultHeader;
  bit          idle_en  = 1'b1;
  bit          stall_en = 1'b1;
  int unsigned hold_left = 0;
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned payload_beats = 0;
  int unsigned ends_good = 0;
  int unsigned ends_bad = 0;
  int unsigned header_writes = 0;

  header_length_sum_deframer_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_header_byte_i(cfg_header_byte_i),
    .rx_valid_i       (rx_valid_i),
    .rx_ready_o       (rx_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .data_o           (data_o),
    .index_o          (index_o),
    .pkt_length_o     (pkt_length_o),
    .checksum_ok_o    (checksum_ok_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result sink: random stall bursts, plus the long hold-off on request
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(0, 8);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any beat on any channel
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((rx_valid_i && rx_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
             quiet, exp_beats.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Frame tracker: one accepted byte, queues the result beat it causes
  function automatic void track_byte(input logic [7:0] b);
    hlsd_pkg::result_t r;
    r = '0;
    case (trk_phase)
      SeekHeader: begin
        if (b == hdr_reg) trk_phase = TakeLength;
      end
      TakeLength: begin
        trk_length = b;
        trk_count  = '0;
        trk_sum    = '0;
        trk_phase  = (b == 8'd0) ? TakeChecksum : TakePayload;
      end
      TakePayload: begin
        r.kind       = hlsd_pkg::KindPayload;
        r.data       = b;
        r.index      = trk_count;
        r.pkt_length = trk_length;
        exp_beats.push_back(r);
        trk_sum   = trk_sum + b;
        trk_count = trk_count + 8'd1;
        if (trk_count == trk_length) trk_phase = TakeChecksum;
      end
      default: begin
        r.kind        = hlsd_pkg::KindEnd;
        r.data        = b;
        r.pkt_length  = trk_length;
        r.checksum_ok = (trk_sum == b);
        exp_beats.push_back(r);
        trk_phase  = SeekHeader;
        trk_count  = '0;
        trk_sum    = '0;
        trk_length = '0;
      end
    endcase
  endfunction

  // Monitor: check result beats, then track rx beats and register writes
  always @(posedge clk_i) begin
    hlsd_pkg::result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (exp_beats.size() == 0) begin
          $error("result beat with none expected: kind %0d data %0d", kind_o, data_o);
          errors++;
        end else begin
          want = exp_beats.pop_front();
          check_field("kind", 8'(want.kind), 8'(kind_o));
          check_field("data", want.data, data_o);
          check_field("index", want.index, index_o);
          check_field("pkt_length", want.pkt_length, pkt_length_o);
          check_field("checksum_ok", 8'(want.checksum_ok), 8'(checksum_ok_o));
        end
        if (kind_o == hlsd_pkg::KindPayload) payload_beats++;
        else if (checksum_ok_o) ends_good++;
        else ends_bad++;
      end
      if (rx_valid_i && rx_ready_o) track_byte(rx_byte_i);
      if (cfg_valid_i && cfg_ready_o) hdr_reg = cfg_header_byte_i;
    end
  end

  // One rx beat; valid stays high unless an idle burst follows
  task automatic send_byte(input logic [7:0] b);
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!rx_ready_o) @(posedge clk_i);
    bytes_sent++;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      rx_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // Stop offering, let every expected beat arrive and the pipeline settle
  task automatic wait_drained();
    rx_valid_i <= 1'b0;
    @(posedge clk_i);
    while (exp_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_header(input logic [7:0] h);
    wait_drained();
    cfg_valid_i       <= 1'b1;
    cfg_header_byte_i <= h;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i    <= 1'b0;
    header_setting = h;
    header_writes++;
  endtask

  // Whole frame with random payload; hdr_bias salts payload with the header
  task automatic send_packet(input int unsigned len, input bit csum_good,
                             input bit hdr_bias);
    logic [7:0] acc;
    logic [7:0] b;
    logic [7:0] skew;
    int unsigned i;
    acc = '0;
    send_byte(header_setting);
    send_byte(len[7:0]);
    for (i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (hdr_bias && $urandom_range(0, 3) == 0) b = header_setting;
      acc = acc + b;
      send_byte(b);
    end
    skew = 8'($urandom_range(1, 255));
    send_byte(csum_good ? acc : acc + skew);
  endtask

  // Hand-picked frames under the reset header
  task automatic test_directed_frames();
    // bytes other than the header are ignored while hunting
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    // zero length, checksum matches a sum of zero
    send_byte(hlsd_pkg::DefaultHeader);
    send_byte(8'h00);
    send_byte(8'h00);
    // zero length, checksum wrong
    send_byte(hlsd_pkg::DefaultHeader);
    send_byte(8'h00);
    send_byte(8'h05);
    // header value inside the payload, sum wraps
    send_byte(hlsd_pkg::DefaultHeader);
    send_byte(8'h02);
    send_byte(8'hFF);
    send_byte(hlsd_pkg::DefaultHeader);
    send_byte(8'hA9);
    // single zero byte, checksum wrong
    send_byte(hlsd_pkg::DefaultHeader);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'hFF);
    wait_drained();
  endtask

  // Header register extremes; the old header must now be ignored
  task automatic test_header_register();
    logic [7:0] sweep [3];
    int unsigned k;
    sweep[0] = 8'h00;
    sweep[1] = 8'hFF;
    sweep[2] = 8'($urandom_range(1, 254));
    for (k = 0; k < 3; k++) begin
      write_header(sweep[k]);
      if (sweep[k] != hlsd_pkg::DefaultHeader) send_byte(hlsd_pkg::DefaultHeader);
      send_byte(sweep[k] ^ 8'h01);
      send_packet(3, 1'b1, 1'b1);
      send_packet(0, 1'b0, 1'b0);
      send_packet(1, 1'b0, 1'b0);
    end
    write_header(hlsd_pkg::DefaultHeader);
  endtask

  // Longest frame, streamed without a buffer limit
  task automatic test_max_length();
    send_packet(255, 1'b1, 1'b1);
    wait_drained();
  endtask

  // Long hold-off on the result side, then a pause until drained
  task automatic test_output_hold();
    hold_left = HoldCycles;
    send_packet(40, 1'b1, 1'b0);
    wait_drained();
    send_packet(5, 1'b0, 1'b0);
    wait_drained();
  endtask

  // Mostly well-formed frames, with noise and cut-short frames between
  task automatic test_random_frames(input int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    int unsigned i;
    start = bytes_sent;
    while (bytes_sent - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        len = $urandom_range(0, 99);
        if (len < 70) len = $urandom_range(0, 8);
        else if (len < 97) len = $urandom_range(9, 40);
        else len = $urandom_range(41, 255);
        send_packet(len, $urandom_range(0, 4) != 0, $urandom_range(0, 3) == 0);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 95) begin
        // frame cut short: later bytes are taken as its payload
        len = $urandom_range(2, 12);
        cut = $urandom_range(0, len - 1);
        send_byte(header_setting);
        send_byte(len[7:0]);
        for (i = 0; i < cut; i++) send_byte(8'($urandom_range(0, 255)));
      end else begin
        // header value used as the length, or as payload and checksum if 64 or more
        send_byte(header_setting);
        if (header_setting < 8'd64) begin
          send_byte(header_setting);
          repeat (header_setting) send_byte(8'($urandom_range(0, 255)));
          send_byte(8'($urandom_range(0, 255)));
        end else begin
          send_byte(8'd1);
          send_byte(header_setting);
          send_byte(header_setting);
        end
      end
    end
  endtask

  // Test sequence
  initial begin
    rst_ni            <= 1'b0;
    rx_valid_i        <= 1'b0;
    rx_byte_i         <= '0;
    cfg_valid_i       <= 1'b0;
    cfg_header_byte_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_frames();
    test_header_register();
    test_max_length();
    test_output_hold();

    test_random_frames(110);
    write_header(8'($urandom_range(0, 255)));
    test_random_frames(110);
    write_header(8'($urandom_range(0, 255)));
    test_random_frames(110);
    idle_en  = 1'b0;
    stall_en = 1'b0;
    write_header(hlsd_pkg::DefaultHeader);
    test_random_frames(110);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (exp_beats.size() != 0) begin
      $error("%0d expected result beats never arrived", exp_beats.size());
      errors++;
    end

    $display("Sent %0d bytes: %0d payload beats, %0d frame ends (%0d sum ok, %0d bad)",
             bytes_sent, payload_beats, ends_good + ends_bad, ends_good, ends_bad);
    $display("Header register written %0d times; %0d mismatches", header_writes, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
